[sv/sfa_pkg.sv]
// Shared constants and types of the spectrum frame averager.
package sfa_pkg;

  localparam int BINS          = 1024;
  localparam int BIN_BITS      = $clog2(BINS);
  localparam int LEN_BITS      = BIN_BITS + 1;
  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 16;
  localparam int SUM_BITS      = 32;
  localparam int INTERVAL_BITS = 32;
  localparam int SEL_BITS      = 10;
  localparam int FREQ_BITS     = 42;
  localparam int CMD_BITS      = 2;
  localparam int STEP_BITS     = $clog2(SUM_BITS);

  localparam logic [CMD_BITS-1:0] CMD_ACC   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_NONE  = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0]   LEN_MAX   = LEN_BITS'(BINS);

  // Largest magnitudes of the signed average, positive and negative.
  localparam logic [SUM_BITS-1:0] AVG_POS_MAX = SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [SUM_BITS-1:0] AVG_NEG_MAX = SUM_BITS'(64'd1 << (SAMPLE_BITS - 1));

  // Configuration register byte addresses.
  localparam int ADDR_BITS = 3;
  localparam logic [ADDR_BITS-1:0] REG_BINS_IN_USE  = 3'd0;
  localparam logic [ADDR_BITS-1:0] REG_BIN_INTERVAL = 3'd4;

  // Request into the sum memory pipeline.
  typedef struct packed {
    logic                          is_read;
    logic                          first;
    logic [BIN_BITS-1:0]           addr;
    logic signed [SAMPLE_BITS-1:0] sample;
  } acc_req_t;

  // Bookkeeping of a read in flight.
  typedef struct packed {
    logic [SEL_BITS-1:0]   sel;
    logic [COUNT_BITS-1:0] frames;
    logic                  empty;
    logic                  saturated;
  } rd_meta_t;

endpackage

[sv/sfa_if.sv]
// Input and result channel interfaces of the spectrum frame averager.
interface sfa_in_if;
  import sfa_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CMD_BITS-1:0]           cmd;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [SEL_BITS-1:0]           bin_select;

  modport source (output valid, output cmd, output sample, output bin_select, input ready);
  modport sink   (input valid, input cmd, input sample, input bin_select, output ready);
endinterface

interface sfa_out_if;
  import sfa_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [SEL_BITS-1:0]           bin_index;
  logic [FREQ_BITS-1:0]          frequency;
  logic signed [SAMPLE_BITS-1:0] average;
  logic [COUNT_BITS-1:0]         frames;
  logic                          empty_res;
  logic                          saturated;

  modport source (output valid, output bin_index, output frequency, output average,
                  output frames, output empty_res, output saturated, input ready);
  modport sink   (input valid, input bin_index, input frequency, input average,
                  input frames, input empty_res, input saturated, output ready);
endinterface

[sv/sfa_accum.sv]
// Bin sum memory with read-modify-write pipeline and write forwarding.
module sfa_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  sfa_pkg::acc_req_t           req_i,
  output logic                        rd_valid_o,
  output logic [sfa_pkg::SUM_BITS-1:0] rd_sum_o
);
  import sfa_pkg::*;

  logic [SUM_BITS-1:0] mem [BINS];
  logic [SUM_BITS-1:0] rdata_q;

  logic                s1_valid_q;
  acc_req_t            s1_q;

  logic                fw_valid_q;
  logic [BIN_BITS-1:0] fw_addr_q;
  logic [SUM_BITS-1:0] fw_data_q;

  logic [SUM_BITS-1:0] old_sum;
  logic [SUM_BITS-1:0] sample_ext;
  logic [SUM_BITS-1:0] wdata;
  logic                we;

  // A write made in the cycle the read was issued is not yet visible in the read data.
  assign old_sum    = (fw_valid_q && (fw_addr_q == s1_q.addr)) ? fw_data_q : rdata_q;
  assign sample_ext = {{(SUM_BITS - SAMPLE_BITS){s1_q.sample[SAMPLE_BITS-1]}}, s1_q.sample};
  assign wdata      = s1_q.first ? sample_ext : old_sum + sample_ext;
  assign we         = s1_valid_q && !s1_q.is_read;

  assign rd_valid_o = s1_valid_q && s1_q.is_read;
  assign rd_sum_o   = old_sum;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[s1_q.addr] <= wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fw_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_valid_i;
      fw_valid_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= req_i;
    if (we) begin
      fw_addr_q <= s1_q.addr;
      fw_data_q <= wdata;
    end
  end

endmodule

[sv/sfa_divider.sv]
// Bit-serial signed divider of a bin sum by the frame count, with saturation.
module sfa_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sfa_pkg::SUM_BITS-1:0]   dividend_i,
  input  logic [sfa_pkg::COUNT_BITS-1:0] divisor_i,
  output logic                           done_o,
  input  logic                           take_i,
  output logic [sfa_pkg::SAMPLE_BITS-1:0] quotient_o
);
  import sfa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [STEP_BITS-1:0]  cnt_q;
  logic                  neg_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [SUM_BITS-1:0]   quo_q;
  logic [COUNT_BITS-1:0] divisor_q;

  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;
  logic [SUM_BITS-1:0]   magnitude;
  logic [SUM_BITS-1:0]   neg_quo;

  assign shifted   = {rem_q, quo_q[SUM_BITS-1]};
  assign trial     = shifted - {1'b0, divisor_q};
  assign fits      = !trial[COUNT_BITS];
  assign magnitude = dividend_i[SUM_BITS-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign neg_quo   = ~quo_q + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (divisor_i == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q == STEP_BITS'(SUM_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      cnt_q     <= '0;
      rem_q     <= '0;
      divisor_q <= divisor_i;
      // An empty read divides by nothing and reports zero.
      neg_q     <= (divisor_i != '0) && dividend_i[SUM_BITS-1];
      quo_q     <= (divisor_i == '0) ? '0 : magnitude;
    end else if (state_q == ST_RUN) begin
      cnt_q <= cnt_q + 1'b1;
      rem_q <= fits ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
      quo_q <= {quo_q[SUM_BITS-2:0], fits};
    end
  end

  assign done_o = (state_q == ST_DONE);

  always_comb begin
    if (neg_q) begin
      quotient_o = (quo_q > AVG_NEG_MAX) ? AVG_NEG_MAX[SAMPLE_BITS-1:0]
                                         : neg_quo[SAMPLE_BITS-1:0];
    end else begin
      quotient_o = (quo_q > AVG_POS_MAX) ? AVG_POS_MAX[SAMPLE_BITS-1:0]
                                         : quo_q[SAMPLE_BITS-1:0];
    end
  end

endmodule

[sv/spectrum_frame_averager_core.sv]
// Top level of the spectrum frame averager: control state, configuration and result register.
// Accumulate, clear and unused commands are taken one per cycle while no read is in progress;
// the bin sums sit in a 1024-entry synchronous memory updated by a two-stage read-modify-write
// with forwarding, so back-to-back samples into the same bin are summed correctly. A read holds
// the input channel through one memory read, then a bit-serial divider that produces one
// quotient bit per cycle over the 32-bit sum, then the handover into the result register.
// A read with no completed frame skips the division. Once the result is in the result
// register, new transactions are taken while it waits. The sums are not cleared by reset or
// by a clear command; the first frame after either overwrites them.
module spectrum_frame_averager_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfa_in_if.sink                          in_i,
  sfa_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfa_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import sfa_pkg::*;

  logic [LEN_BITS-1:0]      bins_in_use_q;
  logic [INTERVAL_BITS-1:0] bin_interval_q;

  logic [BIN_BITS-1:0]      pointer_q;
  logic [COUNT_BITS-1:0]    frames_q;
  logic                     sat_q;
  logic                     rd_busy_q;
  rd_meta_t                 meta_q;

  logic                     out_valid_q;
  logic [SEL_BITS-1:0]      out_index_q;
  logic [FREQ_BITS-1:0]     out_freq_q;
  logic [SAMPLE_BITS-1:0]   out_avg_q;
  logic [COUNT_BITS-1:0]    out_frames_q;
  logic                     out_empty_q;
  logic                     out_sat_q;

  logic                     accept;
  logic                     cfg_write;
  logic [LEN_BITS-1:0]      frame_len;
  logic                     wrap;
  logic                     acc_ok;
  logic                     req_valid;
  acc_req_t                 req;
  logic                     rd_valid;
  logic [SUM_BITS-1:0]      rd_sum;
  logic                     div_done;
  logic [SAMPLE_BITS-1:0]   div_quo;
  logic                     handover;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = paddr[2] ? bin_interval_q : {{(32 - LEN_BITS){1'b0}}, bins_in_use_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_in_use_q  <= LEN_MAX;
      bin_interval_q <= INTERVAL_BITS'(1000);
    end else if (cfg_write) begin
      if (paddr[2] == REG_BIN_INTERVAL[2]) begin
        bin_interval_q <= pwdata[INTERVAL_BITS-1:0];
      end else begin
        bins_in_use_q <= pwdata[LEN_BITS-1:0];
      end
    end
  end

  assign in_i.ready = !rd_busy_q;
  assign accept     = in_i.valid && !rd_busy_q;

  always_comb begin
    priority if (bins_in_use_q == '0) begin
      frame_len = LEN_BITS'(1);
    end else if (bins_in_use_q > LEN_MAX) begin
      frame_len = LEN_MAX;
    end else begin
      frame_len = bins_in_use_q;
    end
  end

  assign wrap   = ({1'b0, pointer_q} + 1'b1) >= frame_len;
  assign acc_ok = frames_q != COUNT_MAX;

  always_comb begin
    req.is_read = (in_i.cmd == CMD_READ);
    req.first   = (frames_q == '0);
    req.addr    = req.is_read ? in_i.bin_select[BIN_BITS-1:0] : pointer_q;
    req.sample  = in_i.sample;
    req_valid   = accept && (req.is_read || (in_i.cmd == CMD_ACC && acc_ok));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pointer_q <= '0;
      frames_q  <= '0;
      sat_q     <= 1'b0;
      rd_busy_q <= 1'b0;
    end else begin
      if (accept) begin
        unique case (in_i.cmd)
          CMD_ACC: begin
            if (!acc_ok) begin
              sat_q <= 1'b1;
            end else if (wrap) begin
              pointer_q <= '0;
              frames_q  <= frames_q + 1'b1;
            end else begin
              pointer_q <= pointer_q + 1'b1;
            end
          end
          CMD_READ: begin
            rd_busy_q <= 1'b1;
          end
          CMD_CLEAR: begin
            pointer_q <= '0;
            frames_q  <= '0;
            sat_q     <= 1'b0;
          end
          CMD_NONE: begin
          end
          default: begin
          end
        endcase
      end else if (handover) begin
        rd_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.cmd == CMD_READ) begin
      meta_q.sel       <= in_i.bin_select;
      meta_q.frames    <= frames_q;
      meta_q.empty     <= (frames_q == '0);
      meta_q.saturated <= sat_q;
    end
  end

  sfa_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .rd_valid_o  (rd_valid),
    .rd_sum_o    (rd_sum)
  );

  sfa_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rd_valid),
    .dividend_i (rd_sum),
    .divisor_i  (meta_q.frames),
    .done_o     (div_done),
    .take_i     (handover),
    .quotient_o (div_quo)
  );

  // The quotient moves into the result register once that register is free.
  assign handover = div_done && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (handover) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (handover) begin
      out_index_q  <= meta_q.sel;
      out_freq_q   <= FREQ_BITS'(meta_q.sel * bin_interval_q);
      out_avg_q    <= div_quo;
      out_frames_q <= meta_q.frames;
      out_empty_q  <= meta_q.empty;
      out_sat_q    <= meta_q.saturated;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.bin_index = out_index_q;
  assign out_o.frequency = out_freq_q;
  assign out_o.average   = out_avg_q;
  assign out_o.frames    = out_frames_q;
  assign out_o.empty_res = out_empty_q;
  assign out_o.saturated = out_sat_q;

endmodule

[verif/tb_spectrum_frame_averager_core.sv]
// Self-checking testbench for the spectrum frame averager core, with its own bin-average predictor.
module tb_spectrum_frame_averager_core;
  import sfa_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;
  localparam int RX_HOLD       = 300;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 30;

  typedef struct {
    logic [SEL_BITS-1:0]           bin_index;
    logic [FREQ_BITS-1:0]          frequency;
    logic signed [SAMPLE_BITS-1:0] average;
    logic [COUNT_BITS-1:0]         frames;
    logic                          empty_res;
    logic                          saturated;
  } bin_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  sfa_in_if  in_if ();
  sfa_out_if out_if ();

  spectrum_frame_averager_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted state of the averager.
  logic [SUM_BITS-1:0]      exp_sums [BINS];
  bit                       bin_written [BINS];
  int                       written_bins [$];
  int                       exp_pointer;
  int                       exp_frames;
  logic                     exp_saturated;
  logic [LEN_BITS-1:0]      exp_len_reg;
  logic [INTERVAL_BITS-1:0] exp_interval;

  bin_report_t pending_reports [$];

  int  mismatches      = 0;
  int  items_sent      = 0;
  int  reports_checked = 0;
  int  settings_used   = 0;
  bit  tx_gaps_on      = 1'b1;
  bit  rx_gaps_on      = 1'b1;
  bit  rx_hold_req     = 1'b0;
  bit  rx_hold_taken   = 1'b0;
  int  rx_hold_left    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int frame_len();
    if (exp_len_reg == '0) return 1;
    if (exp_len_reg > LEN_MAX) return BINS;
    return int'(exp_len_reg);
  endfunction

  function automatic void predict_bin_report(input logic [CMD_BITS-1:0] cmd,
                                             input logic signed [SAMPLE_BITS-1:0] smp,
                                             input logic [SEL_BITS-1:0] sel);
    bin_report_t          rep;
    longint               quot;
    logic [SUM_BITS-1:0]  smp_ext;
    logic [63:0]          freq_full;
    smp_ext = {{(SUM_BITS - SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp};
    case (cmd)
      CMD_ACC: begin
        if (exp_frames >= int'(COUNT_MAX)) begin
          exp_saturated = 1'b1;
        end else begin
          // The first frame after a clear overwrites whatever the bin held.
          if (exp_frames == 0) exp_sums[exp_pointer] = smp_ext;
          else exp_sums[exp_pointer] = exp_sums[exp_pointer] + smp_ext;
          if (!bin_written[exp_pointer]) begin
            bin_written[exp_pointer] = 1'b1;
            written_bins.push_back(exp_pointer);
          end
          if (exp_pointer + 1 >= frame_len()) begin
            exp_pointer = 0;
            exp_frames++;
          end else begin
            exp_pointer++;
          end
        end
      end
      CMD_READ: begin
        freq_full     = 64'(sel) * 64'(exp_interval);
        rep.bin_index = sel;
        rep.frequency = freq_full[FREQ_BITS-1:0];
        rep.frames    = exp_frames[COUNT_BITS-1:0];
        rep.saturated = exp_saturated;
        if (exp_frames == 0) begin
          rep.average   = '0;
          rep.empty_res = 1'b1;
        end else begin
          quot = longint'($signed(exp_sums[sel])) / longint'(exp_frames);
          if (quot > longint'(AVG_POS_MAX)) quot = longint'(AVG_POS_MAX);
          if (quot < -longint'(AVG_NEG_MAX)) quot = -longint'(AVG_NEG_MAX);
          rep.average   = quot[SAMPLE_BITS-1:0];
          rep.empty_res = 1'b0;
        end
        pending_reports.push_back(rep);
      end
      CMD_CLEAR: begin
        exp_pointer   = 0;
        exp_frames    = 0;
        exp_saturated = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Only bins written since reset may be read; anything else falls back to a written one.
  function automatic logic [SEL_BITS-1:0] pick_read_bin();
    int cand;
    if ($urandom_range(0, 99) < 60) cand = $urandom_range(0, frame_len() - 1);
    else cand = $urandom_range(0, BINS - 1);
    if (!bin_written[cand]) cand = written_bins[$urandom_range(0, written_bins.size() - 1)];
    return SEL_BITS'(cand);
  endfunction

  task automatic send_item(input logic [CMD_BITS-1:0] cmd,
                           input logic signed [SAMPLE_BITS-1:0] smp,
                           input logic [SEL_BITS-1:0] sel);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, 4);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.sample     <= smp;
    in_if.bin_select <= sel;
    do @(posedge clk_i); while (!in_if.ready);
    predict_bin_report(cmd, smp, sel);
    items_sent++;
  endtask

  task automatic send_random_item();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) send_item(CMD_ACC, SAMPLE_BITS'($urandom()), SEL_BITS'($urandom()));
    else if (roll < 93) send_item(CMD_READ, SAMPLE_BITS'($urandom()), pick_read_bin());
    else if (roll < 96) send_item(CMD_CLEAR, SAMPLE_BITS'($urandom()), SEL_BITS'($urandom()));
    else send_item(CMD_NONE, SAMPLE_BITS'($urandom()), SEL_BITS'($urandom()));
  endtask

  // Waits until every predicted report has arrived and the pipeline has gone quiet.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_BINS_IN_USE) exp_len_reg = data[LEN_BITS-1:0];
    else exp_interval = data;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] len, input logic [31:0] interval);
    wait_idle();
    write_reg(REG_BINS_IN_USE, len);
    write_reg(REG_BIN_INTERVAL, interval);
    settings_used++;
  endtask

  task automatic test_directed_corners();
    configure(32'd4, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR, 16'sd0, 10'd0);
    send_item(CMD_ACC, 16'sh7FFF, 10'd0);
    send_item(CMD_ACC, -16'sh8000, 10'd0);
    send_item(CMD_READ, 16'sd0, 10'd0);
    send_item(CMD_ACC, 16'sd0, 10'd0);
    send_item(CMD_ACC, -16'sd1, 10'd0);
    // Frame in progress: bins 0 and 1 now hold two samples over one completed frame,
    // which pushes the quotient past both ends of the sample range.
    send_item(CMD_ACC, 16'sh7FFF, 10'd0);
    send_item(CMD_READ, 16'sd0, 10'd0);
    send_item(CMD_ACC, -16'sh8000, 10'd0);
    send_item(CMD_READ, 16'sd0, 10'd1);
    send_item(CMD_NONE, 16'sh7FFF, 10'h3FF);
    send_item(CMD_READ, 16'sd0, 10'd3);
    send_item(CMD_CLEAR, 16'sd0, 10'd0);
    send_item(CMD_READ, 16'sd0, 10'd2);
    // A bin count of zero behaves as one; the average truncates toward zero.
    configure(32'd0, 32'd0);
    send_item(CMD_ACC, -16'sd3, 10'd0);
    send_item(CMD_ACC, 16'sd0, 10'd0);
    send_item(CMD_READ, 16'sd0, 10'd0);
  endtask

  task automatic test_shrunken_frame();
    configure(32'd8, 32'd1000);
    send_item(CMD_CLEAR, 16'sd0, 10'd0);
    repeat (6) send_item(CMD_ACC, SAMPLE_BITS'($urandom()), 10'd0);
    send_item(CMD_READ, 16'sd0, 10'd4);
    // The pointer now sits beyond the new frame end, so the next sample wraps it.
    configure(32'd3, 32'd1000);
    send_item(CMD_ACC, SAMPLE_BITS'($urandom()), 10'd0);
    send_item(CMD_READ, 16'sd0, 10'd5);
    send_item(CMD_ACC, SAMPLE_BITS'($urandom()), 10'd0);
    send_item(CMD_READ, 16'sd0, 10'd0);
  endtask

  task automatic test_full_frame();
    configure(32'd2047, $urandom());
    send_item(CMD_CLEAR, 16'sd0, 10'd0);
    repeat (BINS) send_item(CMD_ACC, SAMPLE_BITS'($urandom()), SEL_BITS'($urandom()));
    send_item(CMD_READ, 16'sd0, 10'd0);
    send_item(CMD_READ, 16'sd0, 10'h3FF);
    send_item(CMD_READ, 16'sd0, SEL_BITS'($urandom()));
    send_item(CMD_ACC, SAMPLE_BITS'($urandom()), 10'd0);
    send_item(CMD_READ, 16'sd0, 10'd0);
  endtask

  task automatic test_backpressure();
    configure(32'd4, 32'd250);
    send_item(CMD_CLEAR, 16'sd0, 10'd0);
    rx_hold_req = 1'b1;
    repeat (8) begin
      send_item(CMD_ACC, SAMPLE_BITS'($urandom()), 10'd0);
      send_item(CMD_READ, 16'sd0, pick_read_bin());
    end
    // Sender pause: nothing more is offered until every report has been taken.
    wait_idle();
    repeat (10) send_random_item();
  endtask

  task automatic test_random_phases();
    logic [31:0] len;
    logic [31:0] interval;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       len = 32'd1;
        1:       len = 32'd2047;
        2:       len = 32'd0;
        3:       len = 32'd1024;
        default: len = ($urandom_range(0, 1) != 0) ? $urandom_range(2, 16)
                                                   : $urandom_range(17, 2047);
      endcase
      case (phase % 3)
        0:       interval = 32'd0;
        1:       interval = 32'hFFFF_FFFF;
        default: interval = $urandom();
      endcase
      configure(len, interval);
      // Phases six and seven run with neither side idling.
      tx_gaps_on = !(phase == 6 || phase == 7);
      rx_gaps_on = tx_gaps_on;
      if ($urandom_range(0, 1) != 0) send_item(CMD_CLEAR, 16'sd0, 10'd0);
      repeat (PHASE_ITEMS) send_random_item();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (rx_hold_req && !rx_hold_taken) begin
      rx_hold_left  = RX_HOLD;
      rx_hold_taken = 1'b1;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(rx_gaps_on && $urandom_range(0, 99) < 10);
    end
  end

  function automatic void compare_field(input string name, input logic signed [63:0] expv,
                                        input logic signed [63:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    bin_report_t exp_rep;
    if (out_if.valid && out_if.ready) begin
      if (pending_reports.size() == 0) begin
        $error("report for bin %0d arrived with none expected", out_if.bin_index);
        mismatches++;
      end else begin
        exp_rep = pending_reports.pop_front();
        compare_field("bin_index", exp_rep.bin_index, out_if.bin_index);
        compare_field("frequency", exp_rep.frequency, out_if.frequency);
        compare_field("average", exp_rep.average, out_if.average);
        compare_field("frames", exp_rep.frames, out_if.frames);
        compare_field("empty_res", exp_rep.empty_res, out_if.empty_res);
        compare_field("saturated", exp_rep.saturated, out_if.saturated);
        reports_checked++;
      end
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("spectrum_frame_averager_core regression: fail");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_NONE;
    in_if.sample     = '0;
    in_if.bin_select = '0;
    exp_pointer      = 0;
    exp_frames       = 0;
    exp_saturated    = 1'b0;
    exp_len_reg      = LEN_BITS'(1024);
    exp_interval     = 32'd1000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_shrunken_frame();
    test_full_frame();
    test_backpressure();
    test_random_phases();
    wait_idle();

    $display("Covered %0d input transactions and %0d checked reports over %0d settings,",
             items_sent, reports_checked, settings_used);
    $display("including a full-size frame, a shrunken frame and a long result stall.");
    if (mismatches == 0) begin
      $display("spectrum_frame_averager_core regression: pass");
    end else begin
      $display("spectrum_frame_averager_core regression: fail");
    end
    $finish;
  end

endmodule
